FILE: rtl/core/wbps_pkg.sv
package wbps_pkg;

    // default sizes of the block
    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_OFFSET_BITS       = 32;

    // pattern storage: 16 bytes in registers, slots above read as literal 0x00
    localparam int PAT_SLOTS    = 32;
    localparam int LEN_W        = 5;
    localparam int MASK_W       = 16;
    localparam int LIMIT_W      = 32;
    localparam int OUT_OFFSET_W = 32;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WILD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 3'd4;

    typedef logic [PAT_SLOTS-1:0][7:0] pat_bytes_t;

    // one result word
    typedef struct packed {
        logic [OUT_OFFSET_W-1:0] match_offset;
        logic                    found;
        logic                    scan_done;
    } res_t;

endpackage

FILE: rtl/core/wildcard_byte_pattern_scanner_top.sv
// Wildcard byte pattern scanner. Haystack bytes stream in on s_tdata, one word per byte,
// with s_tlast on the last byte of a scan. A row of window cells holds the most recent
// bytes and each cell compares its byte against the pattern byte it lines up with, so a
// new byte is taken every cycle while the skid stage is empty, and a match word is
// written into the output buffer as the byte that completes it is taken. A result word
// carries the match start offset on m_tdata with m_tuser set, or, for a last byte without
// a match, zero with m_tuser clear; m_tlast marks the final word of a scan. The output
// holds two words (register plus skid stage), so input keeps flowing through an output
// stall until the skid stage fills. Write the configuration only while the block is idle.
module wildcard_byte_pattern_scanner_top #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int OFFSET_BITS       = wbps_pkg::DEF_OFFSET_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // haystack in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // end_of_scan
    // results out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wbps_pkg::OUT_OFFSET_W-1:0] m_tdata,  // [31:0] match_offset
    output logic                             m_tuser,   // found
    output logic                             m_tlast    // scan_done
);
    import wbps_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    // configuration registers
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [MASK_W-1:0]     wild_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [LIMIT_W-1:0]    limit_reg;

    // scan state
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [LIMIT_W-1:0]     nmatch_reg;
    logic [LIMIT_W-1:0]     nmatch_next;

    logic                          accept;
    logic                          space;
    logic                          found;
    logic [LEN_W-1:0]              len_eff;
    logic [OFFSET_BITS-1:0]        len_m1;
    logic [OFFSET_BITS-1:0]        offset;
    pat_bytes_t                    pattern;
    logic [PAT_SLOTS-1:0]          wild;
    logic [MAX_PATTERN_BYTES-1:0]  hits;
    logic [MAX_PATTERN_BYTES-1:0][7:0] win;
    res_t                          res;
    res_t                          out_res;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = space;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            wild_reg     <= '0;
            len_reg      <= LEN_W'(1);
            limit_reg    <= '1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_wdata;
                CFG_PAT_HIGH: pat_high_reg <= cfg_wdata;
                CFG_WILD:     wild_reg     <= cfg_wdata[MASK_W-1:0];
                CFG_LEN:      len_reg      <= cfg_wdata[LEN_W-1:0];
                CFG_LIMIT:    limit_reg    <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // pattern slots; the upper slots are literal zero bytes, never wild
    always_comb begin
        pattern = '0;
        for (int i = 0; i < 8; i++) begin
            pattern[i]     = pat_low_reg[8*i +: 8];
            pattern[i + 8] = pat_high_reg[8*i +: 8];
        end
        wild = PAT_SLOTS'(wild_reg);
    end

    // length clamped to the window depth
    assign len_eff = (32'(len_reg) > MAX_PATTERN_BYTES) ? LEN_W'(MAX_PATTERN_BYTES) : len_reg;

    // window cell row, newest byte enters cell 0
    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        wbps_cell #(
            .IDX (k)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (accept),
            .byte_in  ((k == 0) ? s_tdata : win[(k == 0) ? 0 : k - 1]),
            .byte_out (win[k]),
            .pattern  (pattern),
            .wild     (wild),
            .len_eff  (len_eff),
            .hit      (hits[k])
        );
    end

    // match decision and start offset
    always_comb begin
        len_m1 = OFFSET_BITS'(len_eff) - OFFSET_BITS'(1);
        offset = pos_reg - len_m1;
        found  = (len_eff != '0) && (pos_reg != POS_MAX) && (pos_reg >= len_m1)
                 && (nmatch_reg < limit_reg) && (&hits);
    end

    // position and match count for the next word
    always_comb begin
        if (s_tlast) begin
            pos_next    = '0;
            nmatch_next = '0;
        end else begin
            pos_next    = (pos_reg != POS_MAX) ? pos_reg + OFFSET_BITS'(1) : pos_reg;
            nmatch_next = found ? nmatch_reg + LIMIT_W'(1) : nmatch_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            nmatch_reg <= '0;
        end else if (accept) begin
            pos_reg    <= pos_next;
            nmatch_reg <= nmatch_next;
        end
    end

    // result word
    always_comb begin
        res.match_offset = found ? OUT_OFFSET_W'(offset) : '0;
        res.found        = found;
        res.scan_done    = s_tlast;
    end

    wbps_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && (found || s_tlast)),
        .push_res  (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = out_res.match_offset;
    assign m_tuser = out_res.found;
    assign m_tlast = out_res.scan_done;

endmodule

FILE: rtl/core/wbps_cell.sv
module wbps_cell #(
    parameter int IDX = 0
) (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic [7:0]                    byte_in,
    output logic [7:0]                    byte_out,
    input  wbps_pkg::pat_bytes_t          pattern,
    input  logic [wbps_pkg::PAT_SLOTS-1:0] wild,
    input  logic [wbps_pkg::LEN_W-1:0]    len_eff,
    output logic                          hit
);
    import wbps_pkg::*;

    logic [7:0]       byte_reg;
    logic [LEN_W-1:0] slot;

    // window byte, moves one cell down per accepted word
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // this cell holds window position IDX, which lines up with pattern byte len-1-IDX
    always_comb begin
        slot = len_eff - LEN_W'(IDX) - LEN_W'(1);
        if (32'(len_eff) <= IDX) begin
            hit = 1'b1;
        end else begin
            hit = wild[slot] || (byte_in == pattern[slot]);
        end
    end

endmodule

FILE: rtl/core/wbps_out_buf.sv
module wbps_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wbps_pkg::res_t  push_res,
    output logic            space,
    output logic            out_valid,
    output wbps_pkg::res_t  out_res,
    input  logic            out_ready
);
    import wbps_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_res_reg;
    res_t skid_res_reg;
    logic out_free;

    // output register can load when empty or being drained this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload: skid word drains first, it is older
    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : push_res;
        end else if (push) begin
            skid_res_reg <= push_res;
        end
    end

endmodule

FILE: rtl/core/wbps_checker.sv
module wbps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a word without a match carries a zero offset
    a_nomatch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("non-match word with nonzero offset");

    // only the end of a scan produces a word without a match
    a_nomatch_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("non-match word that is not the scan end");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // a stalled word holds its content
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output word changed");

    // input stays open while at most one word waits
    a_ready_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |=> s_tready || m_tvalid)
        else $error("input blocked with empty output");

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (.*);
